@@ hdl/stbs_pkg.sv @@
// ----------------------------------------------------------------------------
// stbs_pkg: shared types and constants for the sorted key table
// Table depth, request and result beat layouts, codes and controller states.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int POS_W    = 6;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_NONE   = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_code_t;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [KEY_W-1:0] key_value;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
  } rsp_t;

  // Command from the controller to the key memory
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_WR,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_RESP
  } state_t;

endpackage

@@ hdl/stbs_ram.sv @@
// ----------------------------------------------------------------------------
// stbs_ram: simple dual-port key memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module stbs_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/stbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// stbs_ctrl: request sequencer for the sorted key table
// Runs clear, sorted insert (shift up one entry a cycle) and binary search
// against the key memory, and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module stbs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  stbs_pkg::req_t    req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output stbs_pkg::rsp_t    rsp,
  output stbs_pkg::mem_cmd_t mem_cmd,
  input  logic [stbs_pkg::KEY_W-1:0] mem_rdata
);
  import stbs_pkg::*;

  state_t                  state, state_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [CNT_W-1:0]        idx, idx_next;
  logic [CNT_W-1:0]        lo, lo_next;
  logic [CNT_W-1:0]        hi, hi_next;
  logic [ADDR_W-1:0]       mid, mid_next;
  logic signed [KEY_W-1:0] key, key_next;
  rsp_t                    res, res_next;
  logic                    rsp_valid_next;
  rsp_t                    rsp_next;

  logic signed [KEY_W-1:0] rd_key;
  logic [CNT_W-1:0]        idx_m1, idx_m2;
  logic [CNT_W:0]          mid_sum;

  assign rd_key  = $signed(mem_rdata);
  assign idx_m1  = idx - CNT_W'(1);
  assign idx_m2  = idx - CNT_W'(2);
  assign mid_sum = {1'b0, lo} + {1'b0, hi} - (CNT_W+1)'(1);

  assign req_ready = (state == S_IDLE);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    idx <= idx_next;
    lo  <= lo_next;
    hi  <= hi_next;
    mid <= mid_next;
    key <= key_next;
    res <= res_next;
    rsp <= rsp_next;
  end

  // Next state, memory commands and result
  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    key_next       = key;
    res_next       = res;
    rsp_valid_next = rsp_valid && !rsp_ready;
    rsp_next       = rsp;
    mem_cmd        = '0;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          key_next = req.key_value;
          res_next = '{status: ST_DONE, position: '0};
          case (req.req_type)
            REQ_CLEAR: begin
              count_next = '0;
              state_next = S_RESP;
            end
            REQ_INSERT: begin
              idx_next = count;
              if (count == CNT_W'(CAPACITY)) begin
                res_next.status = ST_FULL;
                state_next      = S_RESP;
              end else if (count == '0) begin
                state_next = S_INS_WR;
              end else begin
                state_next = S_INS_RD;
              end
            end
            REQ_SEARCH: begin
              lo_next    = '0;
              hi_next    = count;
              state_next = S_SRCH_RD;
            end
            default: begin
              state_next = S_RESP;
            end
          endcase
        end
      end

      // Read the entry just below the insert slot
      S_INS_RD: begin
        mem_cmd.re    = 1'b1;
        mem_cmd.raddr = idx_m1[ADDR_W-1:0];
        state_next    = S_INS_CMP;
      end

      // Shift a larger entry up and read the next one below in the same cycle
      S_INS_CMP: begin
        if (rd_key > key) begin
          mem_cmd.we    = 1'b1;
          mem_cmd.waddr = idx[ADDR_W-1:0];
          mem_cmd.wdata = mem_rdata;
          idx_next      = idx_m1;
          if (idx >= CNT_W'(2)) begin
            mem_cmd.re    = 1'b1;
            mem_cmd.raddr = idx_m2[ADDR_W-1:0];
          end else begin
            state_next = S_INS_WR;
          end
        end else begin
          state_next = S_INS_WR;
        end
      end

      // Drop the new key into the open slot
      S_INS_WR: begin
        mem_cmd.we    = 1'b1;
        mem_cmd.waddr = idx[ADDR_W-1:0];
        mem_cmd.wdata = key;
        count_next    = count + CNT_W'(1);
        state_next    = S_RESP;
      end

      // Probe the midpoint of [lo, hi)
      S_SRCH_RD: begin
        if (lo < hi) begin
          mid_next      = ADDR_W'(mid_sum[CNT_W:1]);
          mem_cmd.re    = 1'b1;
          mem_cmd.raddr = ADDR_W'(mid_sum[CNT_W:1]);
          state_next    = S_SRCH_CMP;
        end else begin
          res_next.status = ST_NOT_FOUND;
          state_next      = S_RESP;
        end
      end

      // Narrow the range or stop on a match
      S_SRCH_CMP: begin
        if (rd_key == key) begin
          res_next.status   = ST_FOUND;
          res_next.position = POS_W'(mid);
          state_next        = S_RESP;
        end else if (rd_key < key) begin
          lo_next    = CNT_W'(mid) + CNT_W'(1);
          state_next = S_SRCH_RD;
        end else begin
          hi_next    = CNT_W'(mid);
          state_next = S_SRCH_RD;
        end
      end

      // Hand the result to the output register once it is free
      S_RESP: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next = 1'b1;
          rsp_next       = res;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/sorted_table_binary_search.sv @@
// ----------------------------------------------------------------------------
// sorted_table_binary_search: sorted signed key table with exact-match lookup
// Top level: request sequencer plus a 64-entry key memory.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel (req_valid/req_ready, payload req) takes one request beat:
//   clear, insert or search of a signed 32-bit key. The rsp channel
//   (rsp_valid/rsp_ready, payload rsp) returns exactly one beat per request
//   with a status and, for a hit, the sorted position.
//   One request is in flight at a time; req_ready is high only when idle.
//   From acceptance to rsp_valid, with the output register free:
//     clear, unused code, full insert: straight to the result step
//     insert: straight to the write into an empty table, else a read of the
//       key below the slot, one memory shift per cycle for each larger key,
//       then the write of the new key
//     search: at most 7 probes, each a key memory read and a compare; a hit
//       stops at once, a miss ends on an empty range
//   The result sits in an output register, so a stalled receiver holds the
//   beat while the block returns to idle and accepts the next request; that
//   request then waits in its final step until the register frees up.
//   Reset empties the table (count to zero) and drops any pending result;
//   the memory itself is not cleared.
// ----------------------------------------------------------------------------
module sorted_table_binary_search (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  stbs_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output stbs_pkg::rsp_t rsp
);
  import stbs_pkg::*;

  mem_cmd_t          mem_cmd;
  logic [KEY_W-1:0]  mem_rdata;

  // Request sequencer and output register
  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .mem_cmd   (mem_cmd),
    .mem_rdata (mem_rdata)
  );

  // Sorted key storage
  stbs_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_cmd.we),
    .waddr (mem_cmd.waddr),
    .wdata (mem_cmd.wdata),
    .re    (mem_cmd.re),
    .raddr (mem_cmd.raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ hdl/stbs_checker.sv @@
// ----------------------------------------------------------------------------
// stbs_checker: port-level checks for the sorted key table
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module stbs_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input stbs_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input stbs_pkg::rsp_t rsp
);
  import stbs_pkg::*;

  // Reset drops any pending result beat
  a_rst_clears_rsp: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // Only one request in flight: busy right after a request beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while busy");

  // Position is zero unless the key was found
  a_pos_zero_on_miss: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != ST_FOUND) |-> (rsp.position == '0))
    else $error("nonzero position without a hit");

  // A stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("result beat changed while stalled");

  // A clear or an unused code never reports a hit, miss or full
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && (req.req_type == REQ_CLEAR ||
      req.req_type == REQ_NONE) && !rsp_valid) |=> ##1 (rsp_valid &&
      rsp.status == ST_DONE))
    else $error("clear did not report done");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

@@ bench/tb_sorted_table_binary_search.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_table_binary_search: self-checking bench for the sorted key table
// Drives clear, insert and search beats through the request channel and
// predicts every response from an independent sorted-table model. Directed
// corner cases come first, then random fill/search episodes. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_sorted_table_binary_search;
  timeunit 1ns;
  timeprecision 1ps;

  import stbs_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 80;

  // Predicts one response per request from its own copy of the sorted table
  class sorted_key_predictor;
    logic signed [KEY_W-1:0] keys [CAPACITY];
    int   fill;
    rsp_t pending_results [$];
    int   errors;
    int   n_clear, n_insert, n_full, n_found, n_miss, n_unused, peak_fill;

    function new();
      fill = 0;
      errors = 0;
      n_clear = 0; n_insert = 0; n_full = 0;
      n_found = 0; n_miss = 0; n_unused = 0; peak_fill = 0;
    endfunction

    // Apply an accepted request to the table and queue its response
    function void note_request(req_t r);
      rsp_t e;
      logic signed [KEY_W-1:0] k;
      int slot, lo, hi, mid;
      bit hit;
      k = r.key_value;
      e.status = ST_DONE;
      e.position = '0;
      case (r.req_type)
        REQ_CLEAR: begin
          fill = 0;
          n_clear++;
        end
        REQ_INSERT: begin
          if (fill >= CAPACITY) begin
            e.status = ST_FULL;
            n_full++;
          end else begin
            // place after equal keys, shift larger ones up
            slot = 0;
            while (slot < fill && keys[slot] <= k) slot++;
            for (int i = fill; i > slot; i--) keys[i] = keys[i-1];
            keys[slot] = k;
            fill++;
            n_insert++;
            if (fill > peak_fill) peak_fill = fill;
          end
        end
        REQ_SEARCH: begin
          lo = 0;
          hi = fill - 1;
          hit = 1'b0;
          while (lo <= hi && !hit) begin
            mid = (lo + hi) / 2;
            if (keys[mid] == k) begin
              hit = 1'b1;
              e.position = mid[POS_W-1:0];
            end else if (keys[mid] < k) begin
              lo = mid + 1;
            end else begin
              hi = mid - 1;
            end
          end
          e.status = hit ? ST_FOUND : ST_NOT_FOUND;
          if (hit) n_found++; else n_miss++;
        end
        default: n_unused++;
      endcase
      pending_results.push_back(e);
    endfunction

    // Compare a response beat against the oldest prediction
    function void check_response(rsp_t got);
      rsp_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected response status=%0d position=%0d",
                 $time, got.status, got.position);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (got.status !== e.status) begin
        $display("%0t: status mismatch expected=%0d actual=%0d",
                 $time, e.status, got.status);
        errors++;
      end
      if (got.position !== e.position) begin
        $display("%0t: position mismatch expected=%0d actual=%0d",
                 $time, e.position, got.position);
        errors++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Key stored at a slot of the filled part; used to aim searches at hits
    function logic signed [KEY_W-1:0] key_at(int idx);
      return keys[idx];
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  sorted_key_predictor table_model = new();
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_hold = 0;
  logic stall_level = 1'b1;

  sorted_table_binary_search dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitor both channels at the edge; requests first so predictions lead
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) table_model.note_request(req);
      if (rsp_valid && rsp_ready) table_model.check_response(rsp);
    end
  end

  // Receiver: long ready stretches, short flickers and occasional long stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (stall_hold == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            stall_level = 1'b1;
            stall_hold = $urandom_range(0, 30);
          end
          6, 7, 8: begin
            stall_level = 1'b0;
            stall_hold = $urandom_range(0, 3);
          end
          default: begin
            stall_level = 1'b0;
            stall_hold = $urandom_range(5, 25);
          end
        endcase
      end else begin
        stall_hold--;
      end
      rsp_ready <= stall_level;
    end
  end

  // Watchdog: end the run when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Present one request beat and hold it until accepted, then maybe idle
  task automatic send(input logic [1:0] code, input logic signed [KEY_W-1:0] k);
    int gap;
    req.req_type <= code;
    req.key_value <= k;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 12);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Draw a key from a narrow band (many duplicates) or the full range
  function automatic logic signed [KEY_W-1:0] draw_key(bit narrow);
    int v;
    if (narrow) begin
      v = $urandom_range(0, 15);
      return v - 8;
    end
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Search mostly for stored keys, sometimes a neighbor or a fresh value
  task automatic send_search(bit narrow);
    logic signed [KEY_W-1:0] k;
    int pick;
    pick = $urandom_range(0, 9);
    if (table_model.fill > 0 && pick < 6) begin
      k = table_model.key_at($urandom_range(0, table_model.fill - 1));
    end else if (table_model.fill > 0 && pick < 8) begin
      k = table_model.key_at($urandom_range(0, table_model.fill - 1));
      k = ($urandom_range(0, 1) != 0) ? k + 1 : k - 1;
    end else begin
      k = draw_key(narrow);
    end
    send(REQ_SEARCH, k);
  endtask

  initial begin
    int sent, n_fill, n_probe;
    bit narrow;
    logic [1:0] code;
    sent = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty search, extremes, duplicates, unused code, clear
    send(REQ_SEARCH, 32'sd0);
    send(REQ_INSERT, 32'sh7fff_ffff);
    send(REQ_INSERT, 32'sh8000_0000);
    send(REQ_INSERT, 32'sd0);
    send(REQ_INSERT, -32'sd1);
    send(REQ_INSERT, 32'sd0);
    send(REQ_INSERT, 32'sd0);
    send(REQ_SEARCH, 32'sh8000_0000);
    send(REQ_SEARCH, 32'sh7fff_ffff);
    send(REQ_SEARCH, 32'sd0);
    send(REQ_SEARCH, -32'sd1);
    send(REQ_SEARCH, 32'sd5);
    send(REQ_SEARCH, 32'sh7fff_fffe);
    send(REQ_SEARCH, 32'sh8000_0001);
    send(REQ_NONE, 32'shffff_ffff);
    send(REQ_NONE, 32'sd0);
    send(REQ_SEARCH, 32'sd0);
    send(REQ_CLEAR, 32'sh5a5a_a5a5);
    send(REQ_SEARCH, 32'sd0);
    send(REQ_INSERT, 32'sd1);
    send(REQ_SEARCH, 32'sd1);
    send(REQ_CLEAR, 32'sd0);

    // Random episodes: clear, fill, then a burst of searches with some noise
    while (sent < RANDOM_ITEMS) begin
      narrow = ($urandom_range(0, 2) == 0);
      send(REQ_CLEAR, draw_key(0));
      sent++;
      n_fill = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 70)
                                           : $urandom_range(0, 20);
      for (int i = 0; i < n_fill; i++) begin
        send(REQ_INSERT, draw_key(narrow));
        sent++;
      end
      n_probe = $urandom_range(4, 30);
      for (int i = 0; i < n_probe; i++) begin
        case ($urandom_range(0, 19))
          0: begin
            code = 2'($urandom_range(0, 3));
            send(code, draw_key(0));
          end
          1, 2: send(REQ_INSERT, draw_key(narrow));
          3:    send(REQ_NONE, draw_key(0));
          default: send_search(narrow);
        endcase
        sent++;
      end
    end

    // Drain: release the channel and wait for every response
    req_valid <= 1'b0;
    while (table_model.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d clears, %0d stored inserts, %0d full rejects, %0d unused codes",
             table_model.n_clear, table_model.n_insert, table_model.n_full,
             table_model.n_unused);
    $display("run: %0d hits, %0d misses, deepest table %0d entries, %0d errors",
             table_model.n_found, table_model.n_miss, table_model.peak_fill,
             table_model.errors);
    if (table_model.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
